[design/shpc_pkg.sv]
package shpc_pkg;

   // table geometry
   localparam int MAX_SIGNATURES = 64;
   localparam int MAX_PHASES     = 16;

   localparam int SLOT_W  = (MAX_SIGNATURES > 1) ? $clog2(MAX_SIGNATURES) : 1;
   localparam int CNT_W   = $clog2(MAX_SIGNATURES + 1);
   localparam int PJ_W    = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
   localparam int PC_AW   = (MAX_SIGNATURES * MAX_PHASES > 1) ?
                            $clog2(MAX_SIGNATURES * MAX_PHASES) : 1;

   // fixed field widths
   localparam int PHASE_W  = 5;
   localparam int STATUS_W = 2;
   localparam int SLOTF_W  = 6;
   localparam int HASH_W   = 64;
   localparam int CTR_W    = 32;

   // FNV-1a-style fold over 64-bit words, nonstandard offset basis: prime = 2^40 + 435
   localparam logic [HASH_W-1:0] FNV_BASIS     = 64'd1469598103934665603;
   localparam logic [HASH_W-1:0] FNV_PRIME_LO  = 64'd435;
   localparam int                FNV_PRIME_SHL = 40;

   localparam int HASH_STEPS = 10;
   localparam int HSTEP_W    = $clog2(HASH_STEPS);

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_HIT     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NEW     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

   // register map
   localparam int CSR_AW = 3;
   localparam logic REG_COLLECT_ENABLE = 1'b0;

   typedef struct packed {
      logic                start;      // capture item, reset work registers
      logic                fold;       // one hash fold
      logic                scan;       // advance table search
      logic                hit_take;   // latch matching slot
      logic                insert;     // append new entry
      logic                ovf;        // table full on a miss
      logic                pc_inc;     // write back incremented phase counter
      logic                clr;        // phase row sweep, one counter a cycle
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                load_out;   // move result to output register
   } cmd_type;

   typedef struct packed {
      logic record;     // enabled and phase in range
      logic hash_last;
      logic empty;
      logic full;
      logic hit;
      logic last;       // compared the last valid entry
      logic clr_last;
      logic out_free;
   } stat_type;

   function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [HASH_W-1:0] w);
      logic [HASH_W-1:0] x;
      x = h ^ w;
      return (x << FNV_PRIME_SHL) + x * FNV_PRIME_LO;
   endfunction

endpackage

[design/shpc_ctrl.sv]
module shpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  shpc_pkg::stat_type st,
   output shpc_pkg::cmd_type  cmd
);
   import shpc_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_HASH   = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_HIT_RD = 7'b0001000,
      S_HIT_WR = 7'b0010000,
      S_CLEAR  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            cmd.fold = 1'b1;
            if (st.hash_last) begin
               state_in = st.record ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (st.hit) begin
               cmd.hit_take   = 1'b1;
               cmd.set_status = 1'b1;
               cmd.status     = STAT_HIT;
               state_in       = S_HIT_RD;
            end else if (st.empty || st.last) begin
               cmd.set_status = 1'b1;
               if (st.full) begin
                  cmd.ovf    = 1'b1;
                  cmd.status = STAT_FULL;
                  state_in   = S_FINISH;
               end else begin
                  cmd.insert = 1'b1;
                  cmd.status = STAT_NEW;
                  state_in   = S_CLEAR;
               end
            end
         end
         S_HIT_RD: begin
            state_in = S_HIT_WR;
         end
         S_HIT_WR: begin
            cmd.pc_inc = 1'b1;
            state_in   = S_FINISH;
         end
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (st.clr_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/shpc_dp.sv]
module shpc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  shpc_pkg::cmd_type                    cmd,
   output shpc_pkg::stat_type                   st,
   input  logic                                 collect_enable,
   input  logic signed [shpc_pkg::PHASE_W-1:0]  req_phase,
   input  logic [63:0]                          req_vertex_buffer_id,
   input  logic [63:0]                          req_index_buffer_id,
   input  logic [63:0]                          req_shader_id,
   input  logic [63:0]                          req_declaration_id,
   input  logic [31:0]                          req_vertex_stride,
   input  logic [31:0]                          req_primitive_count,
   input  logic [31:0]                          req_vertex_count,
   input  logic [31:0]                          req_start_index,
   input  logic signed [31:0]                   req_base_vertex,
   input  logic [7:0]                           req_bone_count,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [shpc_pkg::STATUS_W-1:0]        rsp_status,
   output logic [shpc_pkg::SLOTF_W-1:0]         rsp_slot,
   output logic [shpc_pkg::HASH_W-1:0]          rsp_signature_hash,
   output logic [shpc_pkg::CTR_W-1:0]           rsp_draw_total,
   output logic [shpc_pkg::CTR_W-1:0]           rsp_overflow_total
);
   import shpc_pkg::*;

   localparam int SLOTX_W = SLOT_W + SLOTF_W;

   // captured item
   logic [HASH_W-1:0]  word_ff [HASH_STEPS];
   logic [PHASE_W-1:0] ph_ff;
   logic               record_ff;

   // hash fold
   logic [HASH_W-1:0]  hash_ff;
   logic [HSTEP_W-1:0] step_ff;

   // table search
   logic [HASH_W-1:0]  entry_mem [MAX_SIGNATURES];
   logic [HASH_W-1:0]  entry_rd_ff;
   logic [CNT_W-1:0]   scan_idx_ff;
   logic [CNT_W-1:0]   rd_idx_ff;
   logic               cmp_vld_ff;
   logic [CNT_W-1:0]   entry_count_ff;

   // phase counters
   logic [CTR_W-1:0]   pc_mem [MAX_SIGNATURES * MAX_PHASES];
   logic [CTR_W-1:0]   pc_rd_ff;
   logic [PC_AW-1:0]   pc_addr;
   logic [PC_AW-1:0]   pc_col;
   logic [PJ_W-1:0]    clr_idx_ff;
   logic [CTR_W-1:0]   clr_data;

   logic [SLOT_W-1:0]   slot_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [CTR_W-1:0]    draw_ff;
   logic [CTR_W-1:0]    ovf_ff;
   logic                rsp_valid_ff;
   logic [SLOTX_W-1:0]  slot_ext;

   // status back to the controller
   always_comb begin
      st.record    = record_ff;
      st.hash_last = (step_ff == HSTEP_W'(HASH_STEPS - 1));
      st.empty     = (entry_count_ff == '0);
      st.full      = (entry_count_ff == CNT_W'(MAX_SIGNATURES));
      st.hit       = cmp_vld_ff && (entry_rd_ff == hash_ff);
      st.last      = cmp_vld_ff && ((rd_idx_ff + CNT_W'(1)) == entry_count_ff);
      st.clr_last  = (clr_idx_ff == PJ_W'(MAX_PHASES - 1));
      st.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // item capture and hash iteration
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         word_ff[0] <= req_vertex_buffer_id;
         word_ff[1] <= req_index_buffer_id;
         word_ff[2] <= req_shader_id;
         word_ff[3] <= req_declaration_id;
         word_ff[4] <= 64'(req_vertex_stride);
         word_ff[5] <= 64'(req_primitive_count);
         word_ff[6] <= 64'(req_vertex_count);
         word_ff[7] <= 64'(req_start_index);
         word_ff[8] <= 64'(req_base_vertex);
         word_ff[9] <= 64'(req_bone_count);
         ph_ff      <= $unsigned(req_phase);
         record_ff  <= collect_enable && !req_phase[PHASE_W-1] &&
                       (32'($unsigned(req_phase)) < 32'(MAX_PHASES));
         hash_ff    <= FNV_BASIS;
         step_ff    <= '0;
      end else if (cmd.fold) begin
         hash_ff <= fnv_fold(hash_ff, word_ff[step_ff]);
         step_ff <= step_ff + HSTEP_W'(1);
      end
   end

   // signature table: one read a cycle, registered
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         entry_mem[entry_count_ff[SLOT_W-1:0]] <= hash_ff;
      end
      entry_rd_ff <= entry_mem[scan_idx_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff     <= 1'b0;
         entry_count_ff <= '0;
         draw_ff        <= '0;
         ovf_ff         <= '0;
      end else begin
         if (cmd.start) begin
            cmp_vld_ff <= 1'b0;
         end else begin
            cmp_vld_ff <= cmd.scan && (scan_idx_ff < entry_count_ff);
         end
         if (cmd.insert) begin
            entry_count_ff <= entry_count_ff + CNT_W'(1);
         end
         if (cmd.insert || cmd.pc_inc) begin
            draw_ff <= draw_ff + CTR_W'(1);
         end
         if (cmd.ovf) begin
            ovf_ff <= ovf_ff + CTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         scan_idx_ff <= '0;
         slot_ff     <= '0;
         status_ff   <= STAT_IGNORED;
         clr_idx_ff  <= '0;
      end else begin
         if (cmd.scan) begin
            scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         end
         if (cmd.hit_take) begin
            slot_ff <= rd_idx_ff[SLOT_W-1:0];
         end else if (cmd.insert) begin
            slot_ff <= entry_count_ff[SLOT_W-1:0];
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cmd.clr) begin
            clr_idx_ff <= clr_idx_ff + PJ_W'(1);
         end
      end
      rd_idx_ff <= scan_idx_ff;
   end

   // phase counter memory
   assign pc_col   = cmd.clr ? PC_AW'(clr_idx_ff) : PC_AW'(ph_ff);
   assign pc_addr  = PC_AW'(slot_ff) * PC_AW'(MAX_PHASES) + pc_col;
   assign clr_data = (32'(clr_idx_ff) == 32'(ph_ff)) ? CTR_W'(1) : '0;

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         pc_mem[pc_addr] <= clr_data;
      end else if (cmd.pc_inc) begin
         pc_mem[pc_addr] <= pc_rd_ff + CTR_W'(1);
      end
      pc_rd_ff <= pc_mem[pc_addr];
   end

   // output register
   assign slot_ext = SLOTX_W'(slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status         <= status_ff;
         rsp_slot           <= slot_ext[SLOTF_W-1:0];
         rsp_signature_hash <= hash_ff;
         rsp_draw_total     <= draw_ff;
         rsp_overflow_total <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/signature_hash_phase_counter.sv]
// Sequence: the captured words are folded into the hash; unless the item is ignored,
//   the stored entries are then searched. A hit does a counter read-modify-write, an
//   insert sweeps the phase row, a miss on a full table does neither; the result is then
//   loaded into the output register once that register is free.
// Throughput: one item at a time; the next item is taken the cycle after the result
//   enters the output register.
// Reset: synchronous, clears FSM, entry count, draw/overflow totals, result valid and
//   collect_enable; signature and phase counter memories are not cleared and need no clearing pass.
module signature_hash_phase_counter (
   input  logic                                clock,
   input  logic                                reset,
   // draw event channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [shpc_pkg::PHASE_W-1:0] req_phase,
   input  logic [63:0]                         req_vertex_buffer_id,
   input  logic [63:0]                         req_index_buffer_id,
   input  logic [63:0]                         req_shader_id,
   input  logic [63:0]                         req_declaration_id,
   input  logic [31:0]                         req_vertex_stride,
   input  logic [31:0]                         req_primitive_count,
   input  logic [31:0]                         req_vertex_count,
   input  logic [31:0]                         req_start_index,
   input  logic signed [31:0]                  req_base_vertex,
   input  logic [7:0]                          req_bone_count,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [shpc_pkg::STATUS_W-1:0]       rsp_status,
   output logic [shpc_pkg::SLOTF_W-1:0]        rsp_slot,
   output logic [shpc_pkg::HASH_W-1:0]         rsp_signature_hash,
   output logic [shpc_pkg::CTR_W-1:0]          rsp_draw_total,
   output logic [shpc_pkg::CTR_W-1:0]          rsp_overflow_total,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [shpc_pkg::CSR_AW-1:0]         paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import shpc_pkg::*;

   cmd_type  cmd;
   stat_type st;

   logic collect_enable_ff;
   logic reg_idx;
   logic csr_wr;

   // Register file: a single control bit at byte address 0. The word index is
   // paddr[2]; byte offsets within the word are ignored. Writes to index 1 are
   // dropped, reads of it return zero.
   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         collect_enable_ff <= 1'b0;
      end else if (csr_wr && (reg_idx == REG_COLLECT_ENABLE)) begin
         collect_enable_ff <= pwdata[0];
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_COLLECT_ENABLE: prdata = 32'(collect_enable_ff);
         default:            prdata = '0;
      endcase
   end

   // Controller: sequences hash fold, table search, counter update / row
   // sweep and the hand-off into the output register.
   shpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Datapath: item capture, FNV fold unit, signature table, phase counter
   // memory, running totals and the result register.
   shpc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .collect_enable       (collect_enable_ff),
      .req_phase            (req_phase),
      .req_vertex_buffer_id (req_vertex_buffer_id),
      .req_index_buffer_id  (req_index_buffer_id),
      .req_shader_id        (req_shader_id),
      .req_declaration_id   (req_declaration_id),
      .req_vertex_stride    (req_vertex_stride),
      .req_primitive_count  (req_primitive_count),
      .req_vertex_count     (req_vertex_count),
      .req_start_index      (req_start_index),
      .req_base_vertex      (req_base_vertex),
      .req_bone_count       (req_bone_count),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_signature_hash   (rsp_signature_hash),
      .rsp_draw_total       (rsp_draw_total),
      .rsp_overflow_total   (rsp_overflow_total)
   );

endmodule
